FILE: design/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the circular list engine
// request and result payloads, action and status codes, default sizes
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int CAPACITY = 32;
	localparam int MAX_OUT  = 32;

	localparam logic [2:0] ACT_INS_REAR  = 3'd0;
	localparam logic [2:0] ACT_INS_FRONT = 3'd1;
	localparam logic [2:0] ACT_DEL_FRONT = 3'd2;
	localparam logic [2:0] ACT_DEL_REAR  = 3'd3;
	localparam logic [2:0] ACT_REVERSE   = 3'd4;
	localparam logic [2:0] ACT_SORT      = 3'd5;
	localparam logic [2:0] ACT_DUMP      = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data_out;
		logic               last;
	} result_t;

endpackage

FILE: design/cle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ram: generic single write port ram
// one write and one read address per cycle, read data registered
// ----------------------------------------------------------------------------
module cle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/circular_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_engine_unit: circular singly linked list in two rams
// ring of values kept in a value ram and a next-link ram, one action per request
// ----------------------------------------------------------------------------
// Usage: drive cmd and raise start while busy is low; the request is taken at
// that edge; busy, if it rises, goes low in the cycle that shows its last result.
// Results appear on result for one cycle each, marked by strobe; result.last
// flags the final one of a request. The receiver cannot hold results off.
// Every action returns one result, except dump which returns one per value
// (at most 32), in order from the head.
// Each walk step is one registered read of the link/value rams, in S_RD,
// followed by the update in S_EX.
// Head, tail, node count and allocation pointer are held in flops; slots are
// never reclaimed, so inserts report full after CAPACITY inserts in total.
// Reset clears the control state and empties the list; the rams need no clear.
// ----------------------------------------------------------------------------
module circular_list_engine_unit #(
	parameter int CAPACITY = cle_pkg::CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cle_pkg::cmd_t     cmd,
	output logic              strobe,
	output cle_pkg::result_t  result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_INS2 = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_EX   = 3'd4;
	localparam logic [2:0] S_WB   = 3'd5;

	logic [2:0]         state_q;
	logic [2:0]         op_q;
	logic signed [31:0] value_q;
	logic signed [31:0] carry_q;
	logic [AW-1:0]      head_q, tail_q, cur_q, prev_q, slot_q;
	logic [CW-1:0]      count_q, nfree_q, idx_q, pass_q;
	logic               strobe_q;
	cle_pkg::result_t   result_q;

	logic               l_we, v_we;
	logic [AW-1:0]      l_wa, v_wa, l_wd, lnk;
	logic signed [31:0] v_wd, val;
	logic [31:0]        val_raw;
	logic [CW:0]        idx_w;
	logic               at_end, dump_last, full;
	logic [1:0]         idle_st;

	cle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(cur_q), .rdata(lnk)
	);

	cle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_value (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(cur_q), .rdata(val_raw)
	);

	assign val       = $signed(val_raw);
	assign full      = (nfree_q == CW'(CAPACITY));
	assign at_end    = (idx_q == count_q - CW'(1));
	assign idx_w     = {1'b0, idx_q} + (CW + 1)'(1);
	assign dump_last = (idx_w == {1'b0, count_q}) || (idx_w == (CW + 1)'(cle_pkg::MAX_OUT));
	assign busy      = (state_q != S_IDLE);
	assign strobe    = strobe_q;
	assign result    = result_q;

	// status of a request that finishes without a walk
	always_comb begin
		idle_st = cle_pkg::ST_OK;
		case (cmd.action) inside
			cle_pkg::ACT_INS_REAR, cle_pkg::ACT_INS_FRONT: begin
				if (full) begin
					idle_st = cle_pkg::ST_FULL;
				end
			end
			cle_pkg::ACT_DEL_FRONT, cle_pkg::ACT_DEL_REAR, cle_pkg::ACT_DUMP: begin
				if (count_q == '0) begin
					idle_st = cle_pkg::ST_EMPTY;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		l_we = 1'b0;
		l_wa = tail_q;
		l_wd = slot_q;
		v_we = 1'b0;
		v_wa = prev_q;
		v_wd = carry_q;
		case (state_q)
			S_INS: begin
				v_we = 1'b1;
				v_wa = slot_q;
				v_wd = value_q;
				l_we = 1'b1;
				l_wa = slot_q;
				l_wd = (count_q == '0) ? slot_q : head_q;
			end
			S_INS2: begin
				l_we = 1'b1;
			end
			S_EX: begin
				case (op_q)
					cle_pkg::ACT_DEL_FRONT: begin
						l_we = 1'b1;
						l_wd = lnk;
					end
					cle_pkg::ACT_DEL_REAR: begin
						l_we = (lnk == tail_q);
						l_wa = cur_q;
						l_wd = head_q;
					end
					cle_pkg::ACT_REVERSE: begin
						l_we = 1'b1;
						l_wa = cur_q;
						l_wd = prev_q;
					end
					cle_pkg::ACT_SORT: begin
						// keep the larger value moving toward the tail
						v_we = (idx_q != '0);
						v_wd = (carry_q > val) ? val : carry_q;
					end
					default: ;
				endcase
			end
			S_WB: begin
				v_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			nfree_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= cmd.action;
						value_q  <= cmd.value;
						cur_q    <= head_q;
						prev_q   <= tail_q;
						slot_q   <= nfree_q[AW-1:0];
						idx_q    <= '0;
						pass_q   <= '0;
						result_q <= '{status: idle_st, data_out: '0, last: 1'b1};
						case (cmd.action) inside
							cle_pkg::ACT_INS_REAR, cle_pkg::ACT_INS_FRONT: begin
								if (full) begin
									strobe_q <= 1'b1;
								end else begin
									state_q <= S_INS;
								end
							end
							cle_pkg::ACT_DEL_FRONT, cle_pkg::ACT_DEL_REAR: begin
								if (count_q == '0) begin
									strobe_q <= 1'b1;
								end else if (count_q == CW'(1)) begin
									count_q  <= '0;
									strobe_q <= 1'b1;
								end else begin
									state_q <= S_RD;
								end
							end
							cle_pkg::ACT_REVERSE, cle_pkg::ACT_SORT: begin
								if (count_q < CW'(2)) begin
									strobe_q <= 1'b1;
								end else begin
									state_q <= S_RD;
								end
							end
							cle_pkg::ACT_DUMP: begin
								if (count_q == '0) begin
									strobe_q <= 1'b1;
								end else begin
									state_q <= S_RD;
								end
							end
							default: begin
								strobe_q <= 1'b1;
							end
						endcase
					end
				end
				S_INS: begin
					nfree_q <= nfree_q + CW'(1);
					count_q <= count_q + CW'(1);
					if (count_q == '0) begin
						head_q   <= slot_q;
						tail_q   <= slot_q;
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_INS2;
					end
				end
				S_INS2: begin
					if (op_q == cle_pkg::ACT_INS_FRONT) begin
						head_q <= slot_q;
					end else begin
						tail_q <= slot_q;
					end
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_RD: begin
					state_q <= S_EX;
				end
				S_EX: begin
					case (op_q)
						cle_pkg::ACT_DEL_FRONT: begin
							head_q   <= lnk;
							count_q  <= count_q - CW'(1);
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
						end
						cle_pkg::ACT_DEL_REAR: begin
							if (lnk == tail_q) begin
								tail_q   <= cur_q;
								count_q  <= count_q - CW'(1);
								strobe_q <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								cur_q   <= lnk;
								state_q <= S_RD;
							end
						end
						cle_pkg::ACT_REVERSE: begin
							prev_q <= cur_q;
							cur_q  <= lnk;
							idx_q  <= idx_q + CW'(1);
							if (at_end) begin
								head_q   <= tail_q;
								tail_q   <= head_q;
								strobe_q <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_RD;
							end
						end
						cle_pkg::ACT_SORT: begin
							if (idx_q == '0 || !(carry_q > val)) begin
								carry_q <= val;
							end
							prev_q <= cur_q;
							cur_q  <= lnk;
							if (at_end) begin
								state_q <= S_WB;
							end else begin
								idx_q   <= idx_q + CW'(1);
								state_q <= S_RD;
							end
						end
						default: begin
							// dump
							result_q <= '{status: cle_pkg::ST_OK, data_out: val, last: dump_last};
							strobe_q <= 1'b1;
							cur_q    <= lnk;
							idx_q    <= idx_q + CW'(1);
							state_q  <= dump_last ? S_IDLE : S_RD;
						end
					endcase
				end
				S_WB: begin
					// one bubble pass done, tail holds the pass maximum
					if (pass_q == count_q - CW'(2)) begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						pass_q  <= pass_q + CW'(1);
						cur_q   <= head_q;
						idx_q   <= '0;
						state_q <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nfree_q) else $error("node count above allocated slots");
	a_alloc_range: assert property (@(posedge clk) disable iff (!arst_n)
		nfree_q <= CW'(CAPACITY)) else $error("allocation pointer out of range");
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !result_q.last |-> op_q == cle_pkg::ACT_DUMP)
		else $error("multiple results outside dump");
	a_request_taken: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || strobe) else $error("request dropped");
	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> count_q != '0) else $error("walk on empty list");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for circular_list_engine_unit
// directed table of list actions, then random traffic; each result is
// compared with the table's status where the row gives one, else with a
// predictor that keeps its own copy of the ring
module tb_top;
	import cle_pkg::*;

	localparam int N_RANDOM = 310;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    strobe;
	result_t result;

	circular_list_engine_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .strobe(strobe), .result(result)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// predictor copy of the list
	logic signed [31:0] ring_val [CAPACITY];
	logic [4:0]         ring_link [CAPACITY];
	logic [4:0]         ring_head;
	logic               ring_empty;
	int                 alloc_ptr;

	result_t expected_q[$];
	int      n_fail, n_results, n_items, n_full, n_empty_st;

	// slots in ring order from the head
	function automatic int ring_order(output int order [CAPACITY]);
		int n;
		int cur;
		n = 0;
		foreach (order[i]) order[i] = 0;
		if (ring_empty) return 0;
		cur = ring_head;
		do begin
			order[n] = cur;
			n++;
			cur = ring_link[cur];
		end while (cur != ring_head && n < CAPACITY);
		return n;
	endfunction

	function automatic result_t mk_res(logic [1:0] st, logic signed [31:0] d, logic l);
		result_t r;
		r.status = st;
		r.data_out = d;
		r.last = l;
		return r;
	endfunction

	// apply one request to the model ring and queue its results
	task automatic predict_list_op(input cmd_t c, output result_t res_q[$]);
		int order [CAPACITY];
		int n, slot, i, j;
		logic signed [31:0] vals [CAPACITY];
		logic signed [31:0] key;
		logic [1:0] st;
		res_q = {};
		st = ST_OK;
		n = ring_order(order);
		case (c.action)
			ACT_INS_REAR, ACT_INS_FRONT: begin
				if (alloc_ptr >= CAPACITY) st = ST_FULL;
				else begin
					slot = alloc_ptr;
					alloc_ptr++;
					ring_val[slot] = c.value;
					if (ring_empty) begin
						ring_head = slot;
						ring_link[slot] = slot;
						ring_empty = 1'b0;
					end else begin
						ring_link[order[n-1]] = slot;
						ring_link[slot] = ring_head;
						if (c.action == ACT_INS_FRONT) ring_head = slot;
					end
				end
			end
			ACT_DEL_FRONT, ACT_DEL_REAR: begin
				if (ring_empty) st = ST_EMPTY;
				else if (n <= 1) ring_empty = 1'b1;
				else if (c.action == ACT_DEL_FRONT) begin
					ring_head = order[1];
					ring_link[order[n-1]] = ring_head;
				end else ring_link[order[n-2]] = ring_head;
			end
			ACT_REVERSE: begin
				if (n >= 2) begin
					ring_link[order[0]] = order[n-1];
					for (i = 1; i < n; i++) ring_link[order[i]] = order[i-1];
					ring_head = order[n-1];
				end
			end
			ACT_SORT: begin
				for (i = 0; i < n; i++) vals[i] = ring_val[order[i]];
				for (i = 1; i < n; i++) begin
					key = vals[i];
					j = i;
					while (j > 0 && vals[j-1] > key) begin
						vals[j] = vals[j-1];
						j--;
					end
					vals[j] = key;
				end
				for (i = 0; i < n; i++) ring_val[order[i]] = vals[i];
			end
			ACT_DUMP: begin
				if (n == 0) st = ST_EMPTY;
				else begin
					if (n > MAX_OUT) n = MAX_OUT;
					for (i = 0; i < n; i++)
						res_q.push_back(mk_res(ST_OK, ring_val[order[i]], i == n - 1));
				end
			end
			default: ;
		endcase
		if (res_q.size() == 0) res_q.push_back(mk_res(st, '0, 1'b1));
	endtask

	// result checker
	always @(posedge clk) begin
		result_t e;
		if (arst_n && strobe) begin
			n_results++;
			if (result.status == ST_FULL) n_full++;
			if (result.status == ST_EMPTY) n_empty_st++;
			if (expected_q.size() == 0) begin
				$error("unexpected result status=%0d data_out=%0d last=%0b",
					result.status, result.data_out, result.last);
				n_fail++;
			end else begin
				e = expected_q.pop_front();
				if (result.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, result.status);
					n_fail++;
				end
				if (result.data_out !== e.data_out) begin
					$error("data_out: expected %0d, got %0d", e.data_out, result.data_out);
					n_fail++;
				end
				if (result.last !== e.last) begin
					$error("last: expected %0b, got %0b", e.last, result.last);
					n_fail++;
				end
			end
		end
	end

	// hold the request until it is taken, then queue its results
	task automatic send_request(input cmd_t c, input bit typed, input logic [1:0] typed_st);
		result_t res_q[$];
		int gap;
		bit no_idle;
		no_idle = (n_items >= 120 && n_items < 200);
		if (!no_idle && $urandom_range(99) < 30) begin
			start <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predict_list_op(c, res_q);
		if (typed) expected_q.push_back(mk_res(typed_st, '0, 1'b1));
		else foreach (res_q[i]) expected_q.push_back(res_q[i]);
		n_items++;
		@(negedge clk);
	endtask

	typedef struct {
		logic [2:0]         action;
		logic signed [31:0] value;
		bit                 typed;
		logic [1:0]         st;
	} row_t;

	row_t dir_table[] = '{
		'{ACT_DUMP,      32'sd0,           1, ST_EMPTY},
		'{ACT_DEL_FRONT, 32'sd0,           1, ST_EMPTY},
		'{ACT_DEL_REAR,  -32'sd1,          1, ST_EMPTY},
		'{ACT_REVERSE,   32'sd0,           1, ST_OK},
		'{ACT_SORT,      32'sd0,           1, ST_OK},
		'{3'd7,          32'sd5,           1, ST_OK},
		'{ACT_INS_REAR,  32'sh7fffffff,    1, ST_OK},
		'{ACT_REVERSE,   32'sd0,           1, ST_OK},
		'{ACT_SORT,      32'sd0,           1, ST_OK},
		'{ACT_DUMP,      32'sd0,           0, ST_OK},
		'{ACT_INS_FRONT, 32'sh80000000,    1, ST_OK},
		'{ACT_INS_REAR,  32'sd0,           1, ST_OK},
		'{ACT_INS_REAR,  -32'sd1,          1, ST_OK},
		'{ACT_DUMP,      32'sd0,           0, ST_OK},
		'{ACT_SORT,      32'sd0,           0, ST_OK},
		'{ACT_DUMP,      32'sd0,           0, ST_OK},
		'{ACT_REVERSE,   32'sd0,           0, ST_OK},
		'{ACT_DUMP,      32'sd0,           0, ST_OK},
		'{ACT_DEL_FRONT, 32'sd0,           1, ST_OK},
		'{ACT_DEL_REAR,  32'sd0,           1, ST_OK},
		'{ACT_DUMP,      32'sd0,           0, ST_OK},
		'{ACT_INS_FRONT, 32'sh55555555,    1, ST_OK},
		'{ACT_INS_REAR,  32'shaaaaaaaa,    1, ST_OK},
		'{ACT_SORT,      32'sd0,           0, ST_OK},
		'{ACT_DUMP,      32'sd0,           0, ST_OK}
	};

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int p;
		p = $urandom_range(99);
		if (p < 32)      c.action = $urandom_range(1) ? ACT_INS_FRONT : ACT_INS_REAR;
		else if (p < 46) c.action = $urandom_range(1) ? ACT_DEL_FRONT : ACT_DEL_REAR;
		else if (p < 58) c.action = ACT_REVERSE;
		else if (p < 72) c.action = ACT_SORT;
		else if (p < 96) c.action = ACT_DUMP;
		else             c.action = 3'd7;
		case ($urandom_range(9))
			0: c.value = 32'sh7fffffff;
			1: c.value = 32'sh80000000;
			2: c.value = $urandom_range(7) - 3;
			default: c.value = $urandom;
		endcase
		return c;
	endfunction

	initial begin
		cmd_t c;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		ring_head = '0;
		ring_empty = 1'b1;
		alloc_ptr = 0;
		n_fail = 0; n_results = 0; n_items = 0; n_full = 0; n_empty_st = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_table[i]) begin
			c.action = dir_table[i].action;
			c.value = dir_table[i].value;
			send_request(c, dir_table[i].typed, dir_table[i].st);
		end
		repeat (N_RANDOM) send_request(rand_cmd(), 0, ST_OK);
		start <= 1'b0;
		while (expected_q.size() != 0 || busy) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("%0d requests, %0d results checked (%0d full, %0d empty statuses)",
			n_items, n_results, n_full, n_empty_st);
		if (n_fail == 0 && expected_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("timeout with %0d results outstanding", expected_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
